[src/rigid_body_integrator_unit_macros.svh]
// ----------------------------------------------------------------------------
// rigid body integrator assertion macros
// shared assertion forms clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_INTEGRATOR_UNIT_MACROS_SVH
`define RIGID_BODY_INTEGRATOR_UNIT_MACROS_SVH

// same-cycle property
`define RBI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition followed by a consequence in the next cycle
`define RBI_ASSERT_NEXT(name, pre, post, msg) \
  `RBI_ASSERT(name, (pre) |=> (post), msg)

`endif

[src/rbi_pkg.sv]
// ----------------------------------------------------------------------------
// rbi_pkg
// types, codes and helpers shared by the rigid body integrator modules
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

  localparam logic [1:0] OP_FORCE   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_COLLIDE = 2'd2;
  localparam logic [1:0] OP_SETEXT  = 2'd3;

  localparam logic [1:0] BODY_DYNAMIC   = 2'd0;
  localparam logic [1:0] BODY_KINEMATIC = 2'd1;

  localparam logic [2:0] REG_BODY_TYPE   = 3'd0;
  localparam logic [2:0] REG_GRAVITY_EN  = 3'd1;
  localparam logic [2:0] REG_RESTITUTION = 3'd2;
  localparam logic [2:0] REG_FRICTION    = 3'd3;
  localparam logic [2:0] REG_BODY_MASS   = 3'd4;
  localparam logic [2:0] REG_GRAVITY_X   = 3'd5;
  localparam logic [2:0] REG_GRAVITY_Y   = 3'd6;
  localparam logic [2:0] REG_GRAVITY_Z   = 3'd7;

  localparam int unsigned IN_W  = 113;
  localparam int unsigned OUT_W = 193;

  localparam logic signed [31:0] LAND_MIN     = 32'sd66;
  localparam logic [63:0]        EXT_ZERO_MAX = 64'd429496;
  localparam logic [32:0]        MASS_ONE     = 33'd65536;
  localparam logic signed [31:0] GRAV_Y_RST   = -32'sd642253;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_FORCE,
    CMD_EXTSET,
    CMD_TICKSTART,
    CMD_PUSH,
    CMD_MUL,
    CMD_FRSET,
    CMD_DIVSTART_ACC,
    CMD_ACCSET,
    CMD_VELADD,
    CMD_VELSET,
    CMD_FRCCLR,
    CMD_POSADD,
    CMD_EXTDEC,
    CMD_SQACC,
    CMD_EXTCHK,
    CMD_SQRTSTART,
    CMD_LENSET,
    CMD_DIVSTART_DIR,
    CMD_DIRSET,
    CMD_DOTACC,
    CMD_DOTFIN,
    CMD_SSET,
    CMD_VELSUB,
    CMD_OUTLOAD
  } cmd_e;

  typedef enum logic [3:0] {
    M_FRIC_DT,
    M_ACC_DT,
    M_VEL_FR,
    M_GRAVY_DT,
    M_TOT_DT,
    M_EXT_DECAY,
    M_EXT_SQ,
    M_VEC_SQ,
    M_VEL_DIR,
    M_DOT_REST,
    M_DIR_S
  } mul_sel_e;

  typedef struct packed {
    cmd_e       op;
    mul_sel_e   msel;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic [1:0] body_type;
    logic       grav_en;
    logic       div_busy;
    logic       sqrt_busy;
    logic       sq_zero;
    logic       dot_neg;
    logic       out_valid;
    logic       out_free;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[src/rbi_div.sv]
// ----------------------------------------------------------------------------
// rbi_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rbi_div import rbi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] dividend_i,
  input  wire logic [32:0] divisor_i,
  output      logic        busy_o,
  output      logic [47:0] quot_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [33:0] rem_q;
  logic [47:0] dvd_q;
  logic [32:0] dvs_q;
  logic [33:0] r2;
  logic        ge;

  assign r2 = {rem_q[32:0], dvd_q[47]};
  assign ge = r2 >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd48;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (r2 - {1'b0, dvs_q}) : r2;
      dvd_q <= {dvd_q[46:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

[src/rbi_sqrt.sv]
// ----------------------------------------------------------------------------
// rbi_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rbi_sqrt import rbi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output      logic        busy_o,
  output      logic [31:0] root_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [35:0] rem_q;
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [35:0] r2;
  logic [35:0] trial;
  logic        ge;

  assign r2    = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      rad_q  <= rad_i;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (r2 - trial) : r2;
      rad_q  <= {rad_q[61:0], 2'b00};
      root_q <= {root_q[30:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[src/rbi_datapath.sv]
// ----------------------------------------------------------------------------
// rbi_datapath
// body state, configuration, shared multiplier, divider, square root, output
// ----------------------------------------------------------------------------
`default_nettype none

module rbi_datapath import rbi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output      stat_t            stat_o,
  input  wire logic             in_fire_i,
  input  wire logic [1:0]       in_op_i,
  input  wire logic [IN_W-1:0]  in_data_i,
  input  wire logic             cfg_fire_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic             out_ready_i,
  output      logic             out_valid_o,
  output      logic [OUT_W-1:0] out_data_o
);

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] ext_q [3];
  logic signed [31:0] frc_q [3];
  logic               gnd_q;

  logic [1:0]         op_q;
  logic signed [31:0] vec_q [3];
  logic [16:0]        dt_q;

  logic [1:0]         btype_q;
  logic               gen_q;
  logic [16:0]        rest_q;
  logic [16:0]        fric_q;
  logic [30:0]        mass_q;
  logic signed [31:0] grav_q [3];

  logic signed [17:0] fr_q;
  logic signed [31:0] acc_q;
  logic signed [17:0] dir_q [3];
  logic signed [35:0] s_q;
  logic signed [49:0] dot_q;
  logic [63:0]        sq_q;
  logic [31:0]        len_q;
  logic signed [68:0] p_q;
  logic               div_neg_q;

  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;

  logic [1:0]         idx;
  logic signed [31:0] vel_s, ext_s, frc_s, vec_s, grav_s;
  logic signed [17:0] dir_s;
  logic signed [32:0] tot;
  logic signed [19:0] decay;
  logic [17:0]        one_rest;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;
  logic signed [52:0] ps;
  logic signed [63:0] ps64;

  logic               div_start;
  logic signed [31:0] div_x;
  logic [31:0]        div_mag;
  logic [32:0]        div_dvs;
  logic               div_busy;
  logic [47:0]        div_q;
  logic signed [48:0] quot_s;
  logic signed [63:0] acc_w;

  logic               sqrt_start;
  logic               sqrt_busy;
  logic [31:0]        sqrt_root;

  assign idx    = cmd_i.idx;
  assign vel_s  = vel_q[idx];
  assign ext_s  = ext_q[idx];
  assign frc_s  = frc_q[idx];
  assign vec_s  = vec_q[idx];
  assign grav_s = grav_q[idx];
  assign dir_s  = dir_q[idx];

  assign tot      = {vel_s[31], vel_s} + {ext_s[31], ext_s};
  assign decay    = 20'd65536 - ({3'b000, dt_q} + {1'b0, dt_q, 2'b00});
  assign one_rest = 18'd65536 + {1'b0, rest_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.msel)
      M_FRIC_DT: begin
        mul_a = {19'b0, fric_q};
        mul_b = {16'b0, dt_q};
      end
      M_ACC_DT: begin
        mul_a = {{4{acc_q[31]}}, acc_q};
        mul_b = {16'b0, dt_q};
      end
      M_VEL_FR: begin
        mul_a = {{4{vel_s[31]}}, vel_s};
        mul_b = {{15{fr_q[17]}}, fr_q};
      end
      M_GRAVY_DT: begin
        mul_a = {{4{grav_q[1][31]}}, grav_q[1]};
        mul_b = {16'b0, dt_q};
      end
      M_TOT_DT: begin
        mul_a = {{3{tot[32]}}, tot};
        mul_b = {16'b0, dt_q};
      end
      M_EXT_DECAY: begin
        mul_a = {{4{ext_s[31]}}, ext_s};
        mul_b = {{13{decay[19]}}, decay};
      end
      M_EXT_SQ: begin
        mul_a = {{4{ext_s[31]}}, ext_s};
        mul_b = {ext_s[31], ext_s};
      end
      M_VEC_SQ: begin
        mul_a = {{4{vec_s[31]}}, vec_s};
        mul_b = {vec_s[31], vec_s};
      end
      M_VEL_DIR: begin
        mul_a = {{4{vel_s[31]}}, vel_s};
        mul_b = {{15{dir_s[17]}}, dir_s};
      end
      M_DOT_REST: begin
        mul_a = s_q;
        mul_b = {15'b0, one_rest};
      end
      M_DIR_S: begin
        mul_a = s_q;
        mul_b = {{15{dir_s[17]}}, dir_s};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign ps   = p_q[68:16];
  assign ps64 = {{11{ps[52]}}, ps};

  // divider operands, magnitude and sign split
  assign div_start = (cmd_i.op == CMD_DIVSTART_ACC) || (cmd_i.op == CMD_DIVSTART_DIR);
  assign div_x     = (cmd_i.op == CMD_DIVSTART_ACC) ? frc_s : vec_s;
  assign div_mag   = div_x[31] ? (~div_x + 32'd1) : div_x;
  assign div_dvs   = (cmd_i.op == CMD_DIVSTART_ACC) ?
                     ((mass_q == '0) ? MASS_ONE : {2'b00, mass_q}) : {1'b0, len_q};
  assign quot_s    = div_neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign acc_w     = {{15{quot_s[48]}}, quot_s} +
                     (gen_q ? {{32{grav_s[31]}}, grav_s} : 64'sd0);

  assign sqrt_start = cmd_i.op == CMD_SQRTSTART;

  rbi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({div_mag, 16'b0}),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_q)
  );

  rbi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_q),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      op_q     <= in_op_i;
      vec_q[0] <= in_data_i[31:0];
      vec_q[1] <= in_data_i[63:32];
      vec_q[2] <= in_data_i[95:64];
      dt_q     <= in_data_i[112:96];
    end
    if (cmd_i.op == CMD_MUL) begin
      p_q <= prod;
    end
    if (div_start) begin
      div_neg_q <= div_x[31];
    end
    case (cmd_i.op)
      CMD_FRSET:    fr_q       <= 18'sd65536 - ps[17:0];
      CMD_ACCSET:   acc_q      <= sat32(acc_w);
      CMD_LENSET: begin
        len_q <= sqrt_root;
        dot_q <= '0;
      end
      CMD_DIRSET:   dir_q[idx] <= quot_s[17:0];
      CMD_DOTACC:   dot_q      <= dot_q + p_q[49:0];
      CMD_DOTFIN:   s_q        <= {{2{dot_q[49]}}, dot_q[49:16]};
      CMD_SSET:     s_q        <= ps[35:0];
      default: begin
      end
    endcase
  end

  // body state, configuration and ground flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        ext_q[i] <= '0;
        frc_q[i] <= '0;
      end
      gnd_q     <= 1'b0;
      sq_q      <= '0;
      btype_q   <= BODY_DYNAMIC;
      gen_q     <= 1'b1;
      rest_q    <= '0;
      fric_q    <= '0;
      mass_q    <= 31'd65536;
      grav_q[0] <= '0;
      grav_q[1] <= GRAV_Y_RST;
      grav_q[2] <= '0;
    end else begin
      if (cfg_fire_i) begin
        case (cfg_index_i)
          REG_BODY_TYPE:   btype_q   <= cfg_data_i[1:0];
          REG_GRAVITY_EN:  gen_q     <= cfg_data_i[0];
          REG_RESTITUTION: rest_q    <= cfg_data_i[16:0];
          REG_FRICTION:    fric_q    <= cfg_data_i[16:0];
          REG_BODY_MASS:   mass_q    <= cfg_data_i[30:0];
          REG_GRAVITY_X:   grav_q[0] <= cfg_data_i;
          REG_GRAVITY_Y:   grav_q[1] <= cfg_data_i;
          REG_GRAVITY_Z:   grav_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        CMD_FORCE: begin
          if (btype_q == BODY_DYNAMIC) begin
            for (int i = 0; i < 3; i++) begin
              frc_q[i] <= sat32(64'(frc_q[i]) + 64'(vec_q[i]));
            end
          end
        end
        CMD_EXTSET: begin
          for (int i = 0; i < 3; i++) begin
            ext_q[i] <= vec_q[i];
          end
        end
        CMD_TICKSTART: begin
          gnd_q <= 1'b0;
          sq_q  <= '0;
        end
        CMD_PUSH: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= sat32(64'(pos_q[i]) + 64'(vec_q[i]));
          end
          if ((vec_q[1] >= LAND_MIN) && (vel_q[1] < 0)) begin
            gnd_q    <= 1'b1;
            vel_q[1] <= '0;
          end
          sq_q <= '0;
        end
        CMD_VELADD: vel_q[idx] <= sat32(64'(vel_s) + ps64);
        CMD_VELSET: vel_q[idx] <= sat32(ps64);
        CMD_VELSUB: vel_q[idx] <= sat32(64'(vel_s) - ps64);
        CMD_FRCCLR: begin
          for (int i = 0; i < 3; i++) begin
            frc_q[i] <= '0;
          end
        end
        CMD_POSADD: pos_q[idx] <= sat32(64'(pos_q[idx]) + ps64);
        CMD_EXTDEC: ext_q[idx] <= sat32(ps64);
        CMD_SQACC:  sq_q       <= sq_q + p_q[63:0];
        CMD_EXTCHK: begin
          if (sq_q <= EXT_ZERO_MAX) begin
            for (int i = 0; i < 3; i++) begin
              ext_q[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == CMD_OUTLOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_OUTLOAD) begin
      out_data_q <= {gnd_q, vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.item_op   = op_q;
  assign stat_o.body_type = btype_q;
  assign stat_o.grav_en   = gen_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.sqrt_busy = sqrt_busy;
  assign stat_o.sq_zero   = sq_q == '0;
  assign stat_o.dot_neg   = s_q[35];
  assign stat_o.out_valid = out_valid_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[src/rbi_ctrl.sv]
// ----------------------------------------------------------------------------
// rbi_ctrl
// sequencer that issues one datapath command per cycle for each item, except in its gap and wait states
// ----------------------------------------------------------------------------
`default_nettype none

`include "rigid_body_integrator_unit_macros.svh"

module rbi_ctrl import rbi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_fire_i,
  output      logic  in_ready_o,
  input  wire stat_t stat_i,
  output      cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE,
    S_FR_MUL, S_FR_SET, S_ACC_DIV, S_ACC_GAP, S_ACC_WAIT, S_ACC_MUL, S_VEL_ADD,
    S_FRV_MUL, S_FRV_SET, S_FCLR, S_KG_MUL, S_KG_ADD,
    S_POS_MUL, S_POS_ADD, S_DEC_MUL, S_DEC_SET, S_ESQ_MUL, S_ESQ_ACC, S_EXT_CHK,
    S_PSQ_MUL, S_PSQ_ACC, S_SQ_GAP, S_SQ_CHK, S_RT_GAP, S_RT_WAIT,
    S_DIR_DIV, S_DIR_GAP, S_DIR_WAIT, S_DOT_MUL, S_DOT_ACC, S_DOT_FIN, S_DOT_GAP,
    S_DOT_CHK, S_S_SET, S_VS_MUL, S_VS_SUB, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] idx_q;
  cmd_t       cmd_q;
  logic       active;
  logic       dyn;

  assign dyn    = stat_i.body_type == BODY_DYNAMIC;
  assign active = dyn || (stat_i.body_type == BODY_KINEMATIC);

  function automatic cmd_t mk(cmd_e op, mul_sel_e ms, logic [1:0] ix);
    cmd_t c;
    c.op   = op;
    c.msel = ms;
    c.idx  = ix;
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cmd_q   <= mk(CMD_NONE, M_FRIC_DT, 2'd0);
    end else begin
      cmd_q <= mk(CMD_NONE, M_FRIC_DT, idx_q);
      case (state_q)
        S_IDLE: begin
          if (in_fire_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          idx_q <= '0;
          case (stat_i.item_op)
            OP_FORCE: begin
              cmd_q   <= mk(CMD_FORCE, M_FRIC_DT, 2'd0);
              state_q <= S_OUT;
            end
            OP_SETEXT: begin
              cmd_q   <= mk(CMD_EXTSET, M_FRIC_DT, 2'd0);
              state_q <= S_OUT;
            end
            OP_TICK: begin
              if (!active) begin
                state_q <= S_OUT;
              end else begin
                cmd_q <= mk(CMD_TICKSTART, M_FRIC_DT, 2'd0);
                if (dyn) state_q <= S_FR_MUL;
                else if (stat_i.grav_en) state_q <= S_KG_MUL;
                else state_q <= S_POS_MUL;
              end
            end
            default: begin
              if (!active) begin
                state_q <= S_OUT;
              end else begin
                cmd_q   <= mk(CMD_PUSH, M_FRIC_DT, 2'd0);
                state_q <= S_PSQ_MUL;
              end
            end
          endcase
        end
        S_FR_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_FRIC_DT, 2'd0);
          state_q <= S_FR_SET;
        end
        S_FR_SET: begin
          cmd_q   <= mk(CMD_FRSET, M_FRIC_DT, 2'd0);
          idx_q   <= '0;
          state_q <= S_ACC_DIV;
        end
        S_ACC_DIV: begin
          cmd_q   <= mk(CMD_DIVSTART_ACC, M_FRIC_DT, idx_q);
          state_q <= S_ACC_GAP;
        end
        S_ACC_GAP: state_q <= S_ACC_WAIT;
        S_ACC_WAIT: begin
          if (!stat_i.div_busy) begin
            cmd_q   <= mk(CMD_ACCSET, M_FRIC_DT, idx_q);
            state_q <= S_ACC_MUL;
          end
        end
        S_ACC_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_ACC_DT, idx_q);
          state_q <= S_VEL_ADD;
        end
        S_VEL_ADD: begin
          cmd_q <= mk(CMD_VELADD, M_FRIC_DT, idx_q);
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            state_q <= S_FRV_MUL;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_ACC_DIV;
          end
        end
        S_FRV_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_VEL_FR, idx_q);
          state_q <= S_FRV_SET;
        end
        S_FRV_SET: begin
          cmd_q <= mk(CMD_VELSET, M_FRIC_DT, idx_q);
          if (idx_q == 2'd0) begin
            idx_q   <= 2'd2;
            state_q <= S_FRV_MUL;
          end else begin
            state_q <= S_FCLR;
          end
        end
        S_FCLR: begin
          cmd_q   <= mk(CMD_FRCCLR, M_FRIC_DT, 2'd0);
          idx_q   <= '0;
          state_q <= S_POS_MUL;
        end
        S_KG_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_GRAVY_DT, 2'd0);
          state_q <= S_KG_ADD;
        end
        S_KG_ADD: begin
          cmd_q   <= mk(CMD_VELADD, M_FRIC_DT, 2'd1);
          idx_q   <= '0;
          state_q <= S_POS_MUL;
        end
        S_POS_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_TOT_DT, idx_q);
          state_q <= S_POS_ADD;
        end
        S_POS_ADD: begin
          cmd_q   <= mk(CMD_POSADD, M_FRIC_DT, idx_q);
          state_q <= S_DEC_MUL;
        end
        S_DEC_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_EXT_DECAY, idx_q);
          state_q <= S_DEC_SET;
        end
        S_DEC_SET: begin
          cmd_q   <= mk(CMD_EXTDEC, M_FRIC_DT, idx_q);
          state_q <= S_ESQ_MUL;
        end
        S_ESQ_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_EXT_SQ, idx_q);
          state_q <= S_ESQ_ACC;
        end
        S_ESQ_ACC: begin
          cmd_q <= mk(CMD_SQACC, M_FRIC_DT, idx_q);
          if (idx_q == 2'd2) begin
            state_q <= S_EXT_CHK;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_POS_MUL;
          end
        end
        S_EXT_CHK: begin
          cmd_q   <= mk(CMD_EXTCHK, M_FRIC_DT, 2'd0);
          state_q <= S_OUT;
        end
        S_PSQ_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_VEC_SQ, idx_q);
          state_q <= S_PSQ_ACC;
        end
        S_PSQ_ACC: begin
          cmd_q <= mk(CMD_SQACC, M_FRIC_DT, idx_q);
          if (idx_q == 2'd2) begin
            state_q <= S_SQ_GAP;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_PSQ_MUL;
          end
        end
        S_SQ_GAP: state_q <= S_SQ_CHK;
        S_SQ_CHK: begin
          if (stat_i.sq_zero) begin
            state_q <= S_OUT;
          end else begin
            cmd_q   <= mk(CMD_SQRTSTART, M_FRIC_DT, 2'd0);
            state_q <= S_RT_GAP;
          end
        end
        S_RT_GAP: state_q <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (!stat_i.sqrt_busy) begin
            cmd_q   <= mk(CMD_LENSET, M_FRIC_DT, 2'd0);
            idx_q   <= '0;
            state_q <= S_DIR_DIV;
          end
        end
        S_DIR_DIV: begin
          cmd_q   <= mk(CMD_DIVSTART_DIR, M_FRIC_DT, idx_q);
          state_q <= S_DIR_GAP;
        end
        S_DIR_GAP: state_q <= S_DIR_WAIT;
        S_DIR_WAIT: begin
          if (!stat_i.div_busy) begin
            cmd_q <= mk(CMD_DIRSET, M_FRIC_DT, idx_q);
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= S_DOT_MUL;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_DIR_DIV;
            end
          end
        end
        S_DOT_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_VEL_DIR, idx_q);
          state_q <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          cmd_q <= mk(CMD_DOTACC, M_FRIC_DT, idx_q);
          if (idx_q == 2'd2) begin
            state_q <= S_DOT_FIN;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_DOT_MUL;
          end
        end
        S_DOT_FIN: begin
          cmd_q   <= mk(CMD_DOTFIN, M_FRIC_DT, 2'd0);
          state_q <= S_DOT_GAP;
        end
        S_DOT_GAP: state_q <= S_DOT_CHK;
        S_DOT_CHK: begin
          idx_q <= '0;
          if (!stat_i.dot_neg) begin
            state_q <= S_OUT;
          end else if (dyn) begin
            cmd_q   <= mk(CMD_MUL, M_DOT_REST, 2'd0);
            state_q <= S_S_SET;
          end else begin
            state_q <= S_VS_MUL;
          end
        end
        S_S_SET: begin
          cmd_q   <= mk(CMD_SSET, M_FRIC_DT, 2'd0);
          state_q <= S_VS_MUL;
        end
        S_VS_MUL: begin
          cmd_q   <= mk(CMD_MUL, M_DIR_S, idx_q);
          state_q <= S_VS_SUB;
        end
        S_VS_SUB: begin
          cmd_q <= mk(CMD_VELSUB, M_FRIC_DT, idx_q);
          if (idx_q == 2'd2) begin
            state_q <= S_OUT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_VS_MUL;
          end
        end
        S_OUT: begin
          if (stat_i.out_free) begin
            cmd_q   <= mk(CMD_OUTLOAD, M_FRIC_DT, 2'd0);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = state_q == S_IDLE;
  assign cmd_o      = cmd_q;

  `RBI_ASSERT(a_idle_quiet, (state_q == S_IDLE) |-> (cmd_q.op == CMD_NONE || cmd_q.op == CMD_OUTLOAD), "datapath command in flight while idle")
  `RBI_ASSERT_NEXT(a_div_runs, cmd_q.op == CMD_DIVSTART_ACC || cmd_q.op == CMD_DIVSTART_DIR, stat_i.div_busy, "divider did not start")
  `RBI_ASSERT(a_out_free, (cmd_q.op == CMD_OUTLOAD) |-> !stat_i.out_valid, "result overwritten before transaction")

endmodule

`default_nettype wire

[src/rigid_body_integrator_unit.sv]
// ----------------------------------------------------------------------------
// rigid_body_integrator_unit
// one rigid body stepped in Q16.16 fixed point with force, tick and contacts
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per transaction; tuser is the operation, tdata
//   holds vec_x, vec_y, vec_z and delta_time. m_axis returns one result per
//   item: position, own velocity and the ground flag after that item.
//   the cfg channel writes registers by index; write only while idle.
// work per item (one item at a time):
//   add force, set external velocity, static body: at most one update command
//   kinematic tick: passes through the shared multiplier only
//   dynamic tick: multiplier passes and three divider runs
//   collision: multiplier passes and at most the 32-step square root and
//   three divider runs for the push direction
// reset clears body state and loads register defaults; no item is pending.
// the result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver only holds that item at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_integrator_unit import rbi_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [119:0] s_axis_tdata,  // vec_x, vec_y, vec_z, delta_time
  input  wire logic [1:0]   s_axis_tuser,  // operation
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [199:0] m_axis_tdata,  // pos_x/y/z, vel_x/y/z, grounded
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  cmd_t             cmd;
  stat_t            stat;
  logic             in_ready;
  logic             in_fire;
  logic [OUT_W-1:0] out_data;

  assign in_fire       = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tdata  = {7'b0, out_data};

  rbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbi_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_fire_i   (in_fire),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata[IN_W-1:0]),
    .cfg_fire_i  (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for rigid_body_integrator_unit: a queue-fed driver with
// bursty traffic, a stalling result receiver, a fixed-point body predictor
// updated at every accepted transaction and per-field result comparison
// across several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import rbi_pkg::*;

  localparam logic [1:0] BODY_STATIC = 2'd2;
  localparam logic [1:0] BODY_SPARE  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam longint ONE_Q = 65536;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [16:0] dt;
  } body_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;  // vec_x, vec_y, vec_z, delta_time
  logic [1:0]   s_axis_tuser = '0;  // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;       // pos_x/y/z, vel_x/y/z, grounded
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  rigid_body_integrator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // body model state and registers
  logic [1:0]         body_kind;
  logic               grav_on;
  longint             bounce;
  longint             damping;
  longint             mass_q;
  longint             grav[3];
  logic signed [31:0] pos[3];
  logic signed [31:0] vel[3];
  logic signed [31:0] ext_vel[3];
  logic signed [31:0] force_acc[3];
  logic               landed;

  body_item_t     pending_items[$];
  logic [192:0]   expected_states[$];
  body_item_t     cur_item;
  int unsigned    gap_left = 0;
  int unsigned    burst_left = 0;
  int unsigned    ready_pct = 100;
  int unsigned    cycles = 0;
  int unsigned    errors = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic model_reset();
    body_kind = BODY_DYNAMIC;
    grav_on = 1'b1;
    bounce = 0;
    damping = 0;
    mass_q = ONE_Q;
    grav[0] = 0;
    grav[1] = GRAV_Y_RST;
    grav[2] = 0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = '0;
      vel[i] = '0;
      ext_vel[i] = '0;
      force_acc[i] = '0;
    end
    landed = 1'b0;
  endtask

  task automatic model_config(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      REG_BODY_TYPE:   body_kind = d[1:0];
      REG_GRAVITY_EN:  grav_on = d[0];
      REG_RESTITUTION: bounce = longint'(d[16:0]);
      REG_FRICTION:    damping = longint'(d[16:0]);
      REG_BODY_MASS:   mass_q = longint'(d[30:0]);
      REG_GRAVITY_X:   grav[0] = longint'(signed'(d));
      REG_GRAVITY_Y:   grav[1] = longint'(signed'(d));
      REG_GRAVITY_Z:   grav[2] = longint'(signed'(d));
      default: ;
    endcase
  endtask

  task automatic step_tick(input longint dt);
    longint m;
    longint fr;
    longint acc;
    longint decay;
    longint e;
    longint unsigned sq;
    landed = 1'b0;
    if (body_kind == BODY_DYNAMIC) begin
      m = (mass_q == 0) ? ONE_Q : mass_q;
      fr = ONE_Q - fmul(damping, dt);
      for (int i = 0; i < 3; i++) begin
        acc = (longint'(force_acc[i]) * ONE_Q) / m;
        if (grav_on) acc = acc + grav[i];
        acc = longint'(clamp32(acc));
        vel[i] = clamp32(longint'(vel[i]) + fmul(acc, dt));
        force_acc[i] = '0;
      end
      vel[0] = clamp32(fmul(longint'(vel[0]), fr));
      vel[2] = clamp32(fmul(longint'(vel[2]), fr));
    end else if (grav_on) begin
      vel[1] = clamp32(longint'(vel[1]) + fmul(grav[1], dt));
    end
    decay = ONE_Q - 5 * dt;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = clamp32(longint'(pos[i]) +
                       fmul(longint'(vel[i]) + longint'(ext_vel[i]), dt));
      ext_vel[i] = clamp32(fmul(longint'(ext_vel[i]), decay));
      e = longint'(ext_vel[i]);
      sq = sq + longint'(e * e);
    end
    if (sq <= EXT_ZERO_MAX) begin
      for (int i = 0; i < 3; i++) ext_vel[i] = '0;
    end
  endtask

  task automatic step_contact(input longint p[3]);
    longint unsigned sq;
    longint len;
    longint dir[3];
    longint dot;
    longint s;
    sq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = clamp32(longint'(pos[i]) + p[i]);
      sq = sq + longint'(p[i] * p[i]);
    end
    if (p[1] >= LAND_MIN && vel[1] < 0) begin
      landed = 1'b1;
      vel[1] = '0;
    end
    if (sq != 0) begin
      len = longint'(root64(sq));
      for (int i = 0; i < 3; i++) begin
        dir[i] = (p[i] * ONE_Q) / len;
        dot = dot + longint'(vel[i]) * dir[i];
      end
      dot = dot >>> 16;
      if (dot < 0) begin
        s = (body_kind == BODY_DYNAMIC) ? fmul(dot, ONE_Q + bounce) : dot;
        for (int i = 0; i < 3; i++) vel[i] = clamp32(longint'(vel[i]) - fmul(dir[i], s));
      end
    end
  endtask

  task automatic predict_body(input body_item_t it);
    longint v[3];
    logic active;
    v[0] = longint'(signed'(it.x));
    v[1] = longint'(signed'(it.y));
    v[2] = longint'(signed'(it.z));
    active = (body_kind == BODY_DYNAMIC) || (body_kind == BODY_KINEMATIC);
    case (it.op)
      OP_FORCE: begin
        if (body_kind == BODY_DYNAMIC) begin
          for (int i = 0; i < 3; i++) force_acc[i] = clamp32(longint'(force_acc[i]) + v[i]);
        end
      end
      OP_TICK: begin
        if (active) step_tick(longint'(it.dt));
      end
      OP_COLLIDE: begin
        if (active) step_contact(v);
      end
      default: begin
        for (int i = 0; i < 3; i++) ext_vel[i] = v[i][31:0];
      end
    endcase
    expected_states.push_back({landed, vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]});
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_body(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          s_axis_tdata <= {7'd0, cur_item.dt, cur_item.z, cur_item.y, cur_item.x};
          s_axis_tuser <= cur_item.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    logic [192:0] want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 75;
        2: ready_pct <= 40;
        default: ready_pct <= 10;
      endcase
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) < ready_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_states.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", m_axis_tdata[192:0]);
      end else begin
        want = expected_states.pop_front();
        for (int f = 0; f < 7; f++) begin
          if ((f < 6 && m_axis_tdata[f*32 +: 32] != want[f*32 +: 32]) ||
              (f == 6 && m_axis_tdata[192] != want[192])) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch field %0d: expected %h actual %h", f,
                       want[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
            break;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_vec();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 4194303)) - 32'd2097152;
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return 32'd66;
    endcase
  endfunction

  function automatic body_item_t rand_item();
    body_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.op = (r < 20) ? OP_FORCE : (r < 55) ? OP_TICK : (r < 85) ? OP_COLLIDE : OP_SETEXT;
    it.x = rand_vec();
    it.y = rand_vec();
    it.z = rand_vec();
    r = $urandom_range(0, 99);
    if (r < 80) it.dt = 17'($urandom_range(0, 6554));
    else if (r < 95) it.dt = 17'($urandom_range(0, 65536));
    else it.dt = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
    return it;
  endfunction

  function automatic body_item_t mk(input logic [1:0] op, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z,
                                    input logic [16:0] dt);
    body_item_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    it.z = z;
    it.dt = dt;
    return it;
  endfunction

  task automatic drain_body();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_states.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      model_config(3'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n / 2; i++) pending_items.push_back(rand_item());
    drain_body();
    for (int i = n / 2; i < n; i++) pending_items.push_back(rand_item());
    drain_body();
  endtask

  initial begin
    logic [31:0] regs[8];
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    regs = '{BODY_DYNAMIC, 1, 32768, 6554, 65536, 0, GRAV_Y_RST, 0};
    load_regs(regs);
    pending_items.push_back(mk(OP_FORCE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    pending_items.push_back(mk(OP_FORCE, 32'h80000000, 32'h80000000, 32'h80000000, 17'h1ffff));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_TICK, 32'hffffffff, 0, 0, 17'd65536));
    pending_items.push_back(mk(OP_COLLIDE, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_COLLIDE, 0, 32'd65, 0, 0));
    pending_items.push_back(mk(OP_COLLIDE, 0, 32'd66, 0, 0));
    pending_items.push_back(mk(OP_SETEXT, 32'h7fffffff, 32'h80000000, 32'd100, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 17'd655));
    pending_items.push_back(mk(OP_SETEXT, 32'd100, 32'd100, 32'd100, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 17'd655));
    pending_items.push_back(mk(OP_FORCE, 32'd65536, 32'd131072, 32'hffff0000, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 17'd6554));
    pending_items.push_back(mk(OP_COLLIDE, 32'hfffe0000, 32'd65536, 32'd3, 0));
    pending_items.push_back(mk(OP_COLLIDE, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    pending_items.push_back(mk(OP_COLLIDE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 17'd65536));
    pending_items.push_back(mk(OP_COLLIDE, 0, 32'd65536, 0, 0));
    drain_body();
    run_random(160);

    regs = '{BODY_KINEMATIC, 1, $urandom_range(0, 65536), $urandom_range(0, 65536),
             $urandom_range(1, 2000000), $urandom_range(0, 2000000) - 1000000,
             $urandom_range(0, 2000000) - 1000000, $urandom_range(0, 2000000) - 1000000};
    load_regs(regs);
    run_random(120);

    regs = '{BODY_DYNAMIC, 1, 65536, 65536, 0, 32'h7fffffff, 32'h80000000, 0};
    load_regs(regs);
    run_random(100);

    regs = '{BODY_DYNAMIC, 0, 0, 0, 32'h7fffffff, $urandom, $urandom, $urandom};
    load_regs(regs);
    run_random(100);

    regs = '{BODY_STATIC, 1, 1000, 1000, 65536, 0, GRAV_Y_RST, 0};
    load_regs(regs);
    run_random(40);

    regs = '{BODY_SPARE, 1, 0, 0, 65536, 1, 2, 3};
    load_regs(regs);
    run_random(30);

    regs = '{BODY_DYNAMIC, 1, $urandom_range(0, 65536), $urandom_range(0, 20000), 1,
             $urandom_range(0, 2000000) - 1000000, GRAV_Y_RST,
             $urandom_range(0, 2000000) - 1000000};
    load_regs(regs);
    run_random(120);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
